// ===== design/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the LRU cache set
// Operation codes, field widths and the command that drives the line memory.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Operation carried in the input tuser
  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } lcs_func_e;

  // Command from the lookup stage to the line memory
  typedef struct packed {
    logic rd;
    logic wr;
  } lcs_mem_cmd_t;

  // Field widths of one item
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned OFF_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned BCNT_W = 3;
  localparam int unsigned CFG_W  = 4;

  // Bytes moved by one access
  localparam int unsigned WORD_BYTES = 4;
  localparam logic [BCNT_W-1:0] WORD_BYTES_CNT = 3'd4;

  // Ways in use after reset
  localparam logic [CFG_W-1:0] NUM_WAYS_RST = 4'd8;

endpackage

// ===== design/lcs_line_mem.sv =====
// ----------------------------------------------------------------------------
// lcs_line_mem: line data store of the cache set
// One row per way, byte write enables, registered read.
// ----------------------------------------------------------------------------
module lcs_line_mem
  import lcs_pkg::*;
#(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned WAY_W      = 3
) (
  input  logic                           clk_i,
  input  lcs_mem_cmd_t                   cmd_i,
  input  logic [WAY_W-1:0]               addr_i,
  input  logic [LINE_BYTES-1:0]          be_i,
  input  logic [LINE_BYTES-1:0][7:0]     wdata_i,
  output logic [LINE_BYTES-1:0][7:0]     rdata_o
);

  logic [LINE_BYTES-1:0][7:0] mem [WAYS];
  logic [LINE_BYTES-1:0][7:0] rdata_q;

  // Write enabled bytes, register the read row
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      for (int b = 0; b < LINE_BYTES; b++) begin
        if (be_i[b]) begin
          mem[addr_i][b] <= wdata_i[b];
        end
      end
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lru_cache_set.sv =====
// ----------------------------------------------------------------------------
// lru_cache_set: one fully associative cache set with true-LRU replacement
//
//   channel   dir  signals                          contents
//   s_axis    in   tvalid/tready/tdata[71:0]/tuser  access: tag, offset,
//                                                   wdata, byte_count; func
//   m_axis    out  tvalid/tready/tdata[31:0]/tuser  rdata; miss
//   cfg       in   cfg_we_i/cfg_wdata_i[3:0]        num_ways_used
//
// One item per cycle when the output is taken. An item passes through the
// lookup stage (tag compare across all ways in parallel, metadata update,
// line memory access), then the read stage (memory read latency), and then
// the output register, which drives tvalid.
// Reset empties the set at once: no clearing pass, line data needs none.
// A stalled output holds the read stage, which holds the lookup stage.
// ----------------------------------------------------------------------------
module lru_cache_set
  import lcs_pkg::*;
#(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned LINE_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // input items
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [71:0]       s_axis_tdata_i,   // tag, offset, wdata, byte_count
  input  logic              s_axis_tuser_i,   // func
  // result items
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [31:0]       m_axis_tdata_o,   // rdata
  output logic              m_axis_tuser_o    // miss
);

  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned HELD_W = $clog2(WAYS + 1);
  localparam int unsigned BYTE_W = $clog2(LINE_BYTES);
  localparam int unsigned POS_W  = (BYTE_W > OFF_W + 1) ? BYTE_W : OFF_W + 1;
  localparam int unsigned LIM_W  = (HELD_W > CFG_W) ? HELD_W : CFG_W;

  // Configuration and set metadata
  logic [CFG_W-1:0]  num_ways_q;
  logic [HELD_W-1:0] held_q, held_d;
  logic [TAG_W-1:0]  tag_q [WAYS];
  logic [WAY_W-1:0]  rec_q [WAYS];
  logic [WAY_W-1:0]  rec_d [WAYS];

  // Lookup stage
  logic              a_vld_q;
  lcs_func_e         a_func_q;
  logic [TAG_W-1:0]  a_tag_q;
  logic [OFF_W-1:0]  a_off_q;
  logic [DATA_W-1:0] a_wdata_q;
  logic [BCNT_W-1:0] a_bcnt_q;

  // Read stage
  logic              b_vld_q;
  logic              b_rd_hit_q;
  logic              b_miss_q;
  logic [OFF_W-1:0]  b_off_q;

  // Output register
  logic              out_vld_q;
  logic [DATA_W-1:0] out_rdata_q;
  logic              out_miss_q;

  // Flow control
  logic out_free, b_adv, b_stall, a_adv, in_acc;

  // Lookup logic
  logic [WAYS-1:0]   valid, hitv, age0;
  logic              hit, full, is_rd, rd_hit, alloc, age_all;
  logic [WAY_W-1:0]  hit_way, hit_age, vict_way, tgt_way, oldest, ref_age;
  logic [LIM_W-1:0]  limit;
  logic [BCNT_W-1:0] cnt_eff;
  logic [POS_W-1:0]  wpos;

  // Memory interface
  lcs_mem_cmd_t               mem_cmd;
  logic [LINE_BYTES-1:0]      mem_be;
  logic [LINE_BYTES-1:0][7:0] mem_wrow;
  logic [LINE_BYTES-1:0][7:0] mem_rrow;
  logic [DATA_W-1:0]          rd_word;
  logic [POS_W-1:0]           rpos;

  // Advance stages from the output back
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign b_adv           = b_vld_q && out_free;
  assign b_stall         = b_vld_q && !out_free;
  assign a_adv           = a_vld_q && !b_stall;
  assign s_axis_tready_o = !a_vld_q || a_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Compare tags, find the hit, the oldest line and the target way
  always_comb begin
    hit_way  = '0;
    hit_age  = '0;
    vict_way = '0;
    oldest   = WAY_W'(held_q - 1'b1);
    for (int i = 0; i < WAYS; i++) begin
      valid[i] = HELD_W'(i) < held_q;
      hitv[i]  = valid[i] && (tag_q[i] == a_tag_q);
      age0[i]  = valid[i] && (rec_q[i] == '0);
      if (hitv[i]) begin
        hit_way = hit_way | WAY_W'(i);
        hit_age = hit_age | rec_q[i];
      end
      if (valid[i] && (rec_q[i] == oldest)) begin
        vict_way = vict_way | WAY_W'(i);
      end
    end
    hit     = |hitv;
    limit   = (num_ways_q == '0) ? LIM_W'(1) : LIM_W'(num_ways_q);
    full    = (LIM_W'(held_q) >= limit) || (held_q == HELD_W'(WAYS));
    is_rd   = (a_func_q == FUNC_READ);
    rd_hit  = is_rd && hit;
    alloc   = !is_rd && !hit;
    age_all = alloc && !full;
    ref_age = rd_hit ? hit_age : oldest;
    if (hit) begin
      tgt_way = hit_way;
    end else if (full) begin
      tgt_way = vict_way;
    end else begin
      tgt_way = WAY_W'(held_q);
    end
  end

  // On a read hit or an allocation, age lines younger than the touched one and make it newest
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rec_d[i] = rec_q[i];
      if (a_adv && (rd_hit || alloc)) begin
        if (WAY_W'(i) == tgt_way) begin
          rec_d[i] = '0;
        end else if (valid[i] && (age_all || (rec_q[i] < ref_age))) begin
          rec_d[i] = rec_q[i] + 1'b1;
        end
      end
    end
    held_d = (a_adv && age_all) ? held_q + 1'b1 : held_q;
  end

  // Build the write row: zero-fill on allocate, drop bytes past the line end
  always_comb begin
    cnt_eff = (a_bcnt_q > WORD_BYTES_CNT) ? WORD_BYTES_CNT : a_bcnt_q;
    wpos    = '0;
    for (int b = 0; b < LINE_BYTES; b++) begin
      mem_be[b]   = alloc;
      mem_wrow[b] = 8'h00;
      for (int k = 0; k < WORD_BYTES; k++) begin
        wpos = POS_W'(a_off_q) + POS_W'(k);
        if ((POS_W'(b) == wpos) && (BCNT_W'(k) < cnt_eff)) begin
          mem_be[b]   = 1'b1;
          mem_wrow[b] = a_wdata_q[8*k +: 8];
        end
      end
    end
    mem_cmd.rd = a_adv && rd_hit;
    mem_cmd.wr = a_adv && !is_rd;
  end

  lcs_line_mem #(
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .WAY_W      (WAY_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (tgt_way),
    .be_i    (mem_be),
    .wdata_i (mem_wrow),
    .rdata_o (mem_rrow)
  );

  // Pick four bytes from the read row, zero past the line end
  always_comb begin
    rd_word = '0;
    rpos    = '0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      rpos = POS_W'(b_off_q) + POS_W'(k);
      if (b_rd_hit_q && (int'(rpos) < LINE_BYTES)) begin
        rd_word[8*k +: 8] = mem_rrow[rpos[BYTE_W-1:0]];
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ways_q <= NUM_WAYS_RST;
    end else if (cfg_we_i) begin
      num_ways_q <= cfg_wdata_i;
    end
  end

  // Recency and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      for (int i = 0; i < WAYS; i++) begin
        rec_q[i] <= '0;
      end
    end else begin
      held_q <= held_d;
      for (int i = 0; i < WAYS; i++) begin
        rec_q[i] <= rec_d[i];
      end
    end
  end

  // Store the tag of a newly allocated line
  always_ff @(posedge clk_i) begin
    if (a_adv && alloc) begin
      tag_q[tgt_way] <= a_tag_q;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_acc || (a_vld_q && !a_adv);
      if (a_adv) begin
        b_vld_q <= 1'b1;
      end else if (b_adv) begin
        b_vld_q <= 1'b0;
      end
      if (b_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_func_q  <= lcs_func_e'(s_axis_tuser_i);
      a_tag_q   <= s_axis_tdata_i[31:0];
      a_off_q   <= s_axis_tdata_i[36:32];
      a_wdata_q <= s_axis_tdata_i[68:37];
      a_bcnt_q  <= s_axis_tdata_i[71:69];
    end
    if (a_adv) begin
      b_rd_hit_q <= rd_hit;
      b_miss_q   <= !hit;
      b_off_q    <= a_off_q;
    end
    if (b_adv) begin
      out_rdata_q <= rd_word;
      out_miss_q  <= b_miss_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_rdata_q;
  assign m_axis_tuser_o  = out_miss_q;

  // Checks
  a_one_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(age0))
    else $error("more than one valid line is most recent");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HELD_W'(WAYS))
    else $error("fill count above the number of ways");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && age_all |=> held_q == $past(held_q) + 1'b1)
    else $error("allocation into a free way did not raise the fill count");

  a_hit_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && rd_hit |=> rec_q[$past(tgt_way)] == '0)
    else $error("read hit did not make its line most recent");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("miss result carries nonzero data");

endmodule
